/* rtl/slt_pkg.sv */
// ----------------------------------------------------------------------------
// slt_pkg
// Shared constants and types of the sorted linked table.
// ----------------------------------------------------------------------------
package slt_pkg;

    localparam int Depth      = 32;
    localparam int MaxResults = 32;
    localparam int IdxW       = $clog2(Depth);
    localparam int LinkW      = $clog2(Depth + 1);
    localparam int CntW       = $clog2(Depth + 1);
    localparam int KeyW       = 16;
    localparam int PayW       = 64;

    localparam logic [LinkW-1:0] NullLink = LinkW'(Depth);

    localparam logic [1:0] OpInsert = 2'd0;
    localparam logic [1:0] OpDelete = 2'd1;
    localparam logic [1:0] OpSearch = 2'd2;
    localparam logic [1:0] OpList   = 2'd3;

    localparam logic [1:0] StOk      = 2'd0;
    localparam logic [1:0] StMissing = 2'd1;
    localparam logic [1:0] StFull    = 2'd2;
    localparam logic [1:0] StEmpty   = 2'd3;

    // One result word.
    typedef struct packed {
        logic            last;
        logic [PayW-1:0] payload;
        logic [KeyW-1:0] key;
        logic [1:0]      status;
    } t_result;

endpackage

/* rtl/sorted_linked_table_top.sv */
// ----------------------------------------------------------------------------
// sorted_linked_table_top
// Fixed table of records chained by index in ascending key order.
// ----------------------------------------------------------------------------
// Each command walks the chain through a slot memory with a registered read.
// Every record visited takes a read, then a compare on the word that comes
// back. A search or delete ends on a hit or a miss, and a delete that has to
// relink a predecessor reads it back first; an insert stops on a larger key
// or runs off the end of the chain; a full or empty table gives a single
// answer word; a list gives one word per record.
// Back-pressure on the result side stalls a list and the final word. Only one command
// is in flight at a time, and a new command is taken only when the result
// register is empty or its word leaves in the same cycle. The used bits sit
// in flip-flops cleared at reset, so no clearing pass is needed.
module sorted_linked_table_top
    import slt_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // op[1:0], key[17:2], payload[81:18], zero fill to 88 bits
    input  logic [87:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // status[1:0], rec_key[17:2], rec_payload[81:18], zero fill to 88 bits
    output logic [87:0]  m_axis_tdata,
    output logic         m_axis_tlast
);

    localparam logic [2:0] SIdle = 3'd0;
    localparam logic [2:0] SRead = 3'd1;
    localparam logic [2:0] SChk  = 3'd2;
    localparam logic [2:0] SLink = 3'd3;
    localparam logic [2:0] SOut  = 3'd4;

    // Slot memory: key, payload, link in one word.
    localparam int MemW = KeyW + PayW + LinkW;
    logic [MemW-1:0] mem [Depth];
    logic [MemW-1:0] r_rd;
    logic [IdxW-1:0] rd_addr;
    logic            rd_en;
    logic            wr_en;
    logic [IdxW-1:0] wr_addr;
    logic [MemW-1:0] wr_data;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd <= mem[rd_addr];
        end
    end

    logic [KeyW-1:0]  rd_key;
    logic [PayW-1:0]  rd_pay;
    logic [LinkW-1:0] rd_link;
    assign rd_key  = r_rd[KeyW-1:0];
    assign rd_pay  = r_rd[KeyW+PayW-1:KeyW];
    assign rd_link = r_rd[MemW-1:KeyW+PayW];

    logic [2:0]       r_state, n_state;
    logic [Depth-1:0] r_used, n_used;
    logic [LinkW-1:0] r_head, n_head;
    logic [CntW-1:0]  r_count, n_count;
    logic [1:0]       r_op, n_op;
    logic [KeyW-1:0]  r_key, n_key;
    logic [PayW-1:0]  r_pay, n_pay;
    logic [LinkW-1:0] r_cur, n_cur;
    logic [LinkW-1:0] r_prev, n_prev;
    logic [CntW-1:0]  r_n, n_n;
    logic [IdxW-1:0]  r_free, n_free;
    logic             r_ovalid, n_ovalid;
    t_result          r_res, n_res;

    // Lowest free slot.
    logic [IdxW-1:0] free_idx;
    logic            free_any;
    always_comb begin
        free_idx = '0;
        free_any = 1'b0;
        for (int i = Depth - 1; i >= 0; i--) begin
            if (!r_used[i]) begin
                free_idx = IdxW'(i);
                free_any = 1'b1;
            end
        end
    end

    logic out_free;
    assign out_free      = !r_ovalid || m_axis_tready;
    assign s_axis_tready = (r_state == SIdle) && out_free;

    logic [CntW-1:0] lim;
    assign lim = (r_count < CntW'(MaxResults)) ? r_count : CntW'(MaxResults);

    always_comb begin
        n_state  = r_state;
        n_used   = r_used;
        n_head   = r_head;
        n_count  = r_count;
        n_op     = r_op;
        n_key    = r_key;
        n_pay    = r_pay;
        n_cur    = r_cur;
        n_prev   = r_prev;
        n_n      = r_n;
        n_free   = r_free;
        n_res    = r_res;
        n_ovalid = r_ovalid && !m_axis_tready;
        rd_en    = 1'b0;
        rd_addr  = r_cur[IdxW-1:0];
        wr_en    = 1'b0;
        wr_addr  = r_free;
        wr_data  = {r_head, r_pay, r_key};

        unique case (r_state)
            SIdle: begin
                if (s_axis_tvalid && s_axis_tready) begin
                    n_op   = s_axis_tdata[1:0];
                    n_key  = s_axis_tdata[17:2];
                    n_pay  = s_axis_tdata[81:18];
                    n_cur  = r_head;
                    n_prev = NullLink;
                    n_n    = '0;
                    n_free = free_idx;
                    n_state = SRead;
                end
            end
            SRead: begin
                // Decide whether to read the next slot or finish.
                priority if (r_op == OpInsert && (!free_any || r_count >= CntW'(Depth)))
                begin
                    n_res   = '{last: 1'b1, payload: '0, key: r_key, status: StFull};
                    n_state = SOut;
                end else if (r_op != OpInsert && r_count == '0) begin
                    n_res   = '{last: 1'b1, payload: '0,
                                key: (r_op == OpList) ? '0 : r_key, status: StEmpty};
                    n_state = SOut;
                end else if ((r_op == OpList ? r_n < lim : r_n < r_count)
                             && r_cur < NullLink) begin
                    rd_en   = 1'b1;
                    n_state = SChk;
                end else if (r_op == OpInsert) begin
                    n_state = SLink;
                end else begin
                    n_res   = '{last: 1'b1, payload: '0, key: r_key, status: StMissing};
                    n_state = SOut;
                end
            end
            SChk: begin
                unique case (r_op)
                    OpInsert: begin
                        if (rd_key > r_key) begin
                            n_state = SLink;
                        end else begin
                            n_prev  = r_cur;
                            n_cur   = rd_link;
                            n_n     = r_n + 1'b1;
                            n_state = SRead;
                        end
                    end
                    OpList: begin
                        if (out_free) begin
                            n_n      = r_n + 1'b1;
                            n_cur    = rd_link;
                            n_res    = '{last: (r_n + 1'b1 == lim) || rd_link >= NullLink,
                                         payload: rd_pay, key: rd_key, status: StOk};
                            n_ovalid = 1'b1;
                            n_state  = ((r_n + 1'b1 == lim) || rd_link >= NullLink)
                                       ? SIdle : SRead;
                        end
                    end
                    default: begin
                        if (rd_key == r_key) begin
                            n_res   = '{last: 1'b1, payload: rd_pay, key: rd_key,
                                        status: StOk};
                            n_state = SOut;
                            if (r_op == OpDelete) begin
                                n_used[r_cur[IdxW-1:0]] = 1'b0;
                                n_count = r_count - 1'b1;
                                if (r_prev == NullLink || r_count == CntW'(1)) begin
                                    n_head = (r_count == CntW'(1)) ? NullLink : rd_link;
                                end else begin
                                    // Rewrite the predecessor's link: read it back first.
                                    n_cur   = rd_link;
                                    n_state = SLink;
                                end
                            end
                        end else begin
                            n_prev  = r_cur;
                            n_cur   = rd_link;
                            n_n     = r_n + 1'b1;
                            n_state = SRead;
                        end
                    end
                endcase
            end
            SLink: begin
                if (r_op == OpInsert) begin
                    // r_cur is the successor; r_prev gets the new slot.
                    if (r_prev == NullLink) begin
                        wr_en   = 1'b1;
                        wr_addr = r_free;
                        wr_data = {(r_count == '0) ? NullLink : r_head, r_pay, r_key};
                        n_head  = {1'b0, r_free};
                        n_used[r_free] = 1'b1;
                        n_count = r_count + 1'b1;
                        n_res   = '{last: 1'b1, payload: r_pay, key: r_key, status: StOk};
                        n_state = SOut;
                    end else begin
                        // Read the predecessor, then write both slots.
                        rd_en   = 1'b1;
                        rd_addr = r_prev[IdxW-1:0];
                        n_prev  = {1'b1, r_prev[IdxW-1:0]} ;
                        n_state = SOut;
                        n_op    = OpInsert;
                        n_n     = '1;
                    end
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = r_prev[IdxW-1:0];
                    n_n     = '1;
                    n_state = SOut;
                end
            end
            SOut: begin
                if (r_n == '1) begin
                    // Predecessor word is in r_rd: finish the relink.
                    if (r_op == OpInsert) begin
                        wr_en   = 1'b1;
                        wr_addr = r_prev[IdxW-1:0];
                        wr_data = {{1'b0, r_free}, rd_pay, rd_key};
                        n_n     = '0;
                        n_prev  = {1'b0, r_prev[IdxW-1:0]};
                        // Second write: the new slot takes the old link.
                        n_cur   = rd_link;
                        n_state = SLink;
                        n_op    = OpList;
                    end else begin
                        wr_en   = 1'b1;
                        wr_addr = r_prev[IdxW-1:0];
                        wr_data = {r_cur, rd_pay, rd_key};
                        n_n     = '0;
                    end
                end else if (out_free) begin
                    n_ovalid = 1'b1;
                    n_state  = SIdle;
                end
            end
            default: n_state = SIdle;
        endcase

        // Second half of a mid-chain insert, entered as SLink with r_op OpList.
        if (r_state == SLink && r_op == OpList) begin
            rd_en   = 1'b0;
            wr_en   = 1'b1;
            wr_addr = r_free;
            wr_data = {r_cur, r_pay, r_key};
            n_used  = r_used;
            n_used[r_free] = 1'b1;
            n_count = r_count + 1'b1;
            n_res   = '{last: 1'b1, payload: r_pay, key: r_key, status: StOk};
            n_op    = OpInsert;
            n_n     = '0;
            n_state = SOut;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= SIdle;
            r_used   <= '0;
            r_head   <= NullLink;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_used   <= n_used;
            r_head   <= n_head;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
        end
        r_op   <= n_op;
        r_key  <= n_key;
        r_pay  <= n_pay;
        r_cur  <= n_cur;
        r_prev <= n_prev;
        r_n    <= n_n;
        r_free <= n_free;
        r_res  <= n_res;
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {6'd0, r_res.payload, r_res.key, r_res.status};
    assign m_axis_tlast  = r_res.last;

endmodule

/* tb/tb_sorted_linked_table_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sorted_linked_table_top
// Self-checking bench for the sorted linked table.
// ----------------------------------------------------------------------------
// Commands go in from a queue through a clocked driver with random gaps. An
// internal table model predicts every result word, and a clocked monitor with
// random back-pressure compares each word against the oldest prediction.
module tb_sorted_linked_table_top;
    import slt_pkg::*;

    // The op sits in the lowest bits, as on the bus.
    typedef struct packed {
        logic [PayW-1:0] payload;
        logic [KeyW-1:0] key;
        logic [1:0]      op;
    } t_cmd;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [87:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [87:0] m_axis_tdata;
    logic        m_axis_tlast;

    sorted_linked_table_top DUT (.*);

    // Table model state.
    logic [KeyW-1:0] tbl_key [Depth];
    logic [PayW-1:0] tbl_pay [Depth];
    int              tbl_next[Depth];
    bit              tbl_used[Depth];
    int              tbl_head;
    int              tbl_count;

    t_cmd    cmd_q[$];
    t_result result_q[$];
    int      errors;
    int      idle_cycles;
    int      send_gap;
    int      recv_gap;
    bit      hold_send;
    bit      done_feeding;

    function automatic t_result mk(logic [1:0] st, logic [KeyW-1:0] k,
                                   logic [PayW-1:0] p, logic l);
        t_result r;
        r.status  = st;
        r.key     = k;
        r.payload = p;
        r.last    = l;
        return r;
    endfunction

    // Applies one command to the table model and queues the words it yields.
    function automatic void table_apply(t_cmd c);
        int slot, prv, cur, n;
        slot = -1;
        prv  = -1;
        cur  = tbl_head;
        case (c.op)
            OpInsert: begin
                for (int i = 0; i < Depth; i++)
                    if (!tbl_used[i] && slot < 0) slot = i;
                if (slot < 0) begin
                    result_q.push_back(mk(StFull, c.key, '0, 1'b1));
                    return;
                end
                for (n = 0; n < tbl_count; n++) begin
                    if (tbl_key[cur] > c.key) break;
                    prv = cur;
                    cur = tbl_next[cur];
                end
                tbl_key[slot]  = c.key;
                tbl_pay[slot]  = c.payload;
                tbl_used[slot] = 1'b1;
                if (prv < 0) begin
                    tbl_next[slot] = (tbl_count == 0) ? -1 : tbl_head;
                    tbl_head = slot;
                end else begin
                    tbl_next[slot] = tbl_next[prv];
                    tbl_next[prv]  = slot;
                end
                tbl_count++;
                result_q.push_back(mk(StOk, c.key, c.payload, 1'b1));
            end
            OpDelete, OpSearch: begin
                if (tbl_count == 0) begin
                    result_q.push_back(mk(StEmpty, c.key, '0, 1'b1));
                    return;
                end
                for (n = 0; n < tbl_count; n++) begin
                    if (tbl_key[cur] == c.key) break;
                    prv = cur;
                    cur = tbl_next[cur];
                end
                if (n == tbl_count) begin
                    result_q.push_back(mk(StMissing, c.key, '0, 1'b1));
                    return;
                end
                result_q.push_back(mk(StOk, tbl_key[cur], tbl_pay[cur], 1'b1));
                if (c.op == OpDelete) begin
                    if (prv < 0) tbl_head = tbl_next[cur];
                    else tbl_next[prv] = tbl_next[cur];
                    tbl_used[cur] = 1'b0;
                    tbl_count--;
                    if (tbl_count == 0) tbl_head = -1;
                end
            end
            default: begin
                if (tbl_count == 0) begin
                    result_q.push_back(mk(StEmpty, '0, '0, 1'b1));
                    return;
                end
                for (n = 0; n < tbl_count && n < MaxResults; n++) begin
                    result_q.push_back(mk(StOk, tbl_key[cur], tbl_pay[cur],
                                          n == tbl_count - 1 || n == MaxResults - 1));
                    cur = tbl_next[cur];
                end
            end
        endcase
    endfunction

    function automatic t_cmd cmd(logic [1:0] op, logic [KeyW-1:0] k, logic [PayW-1:0] p);
        t_cmd c;
        c.op      = op;
        c.key     = k;
        c.payload = p;
        return c;
    endfunction

    function automatic logic [PayW-1:0] rand_pay();
        return {$urandom, $urandom};
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        logic [1:0] op;
        int         sel;
        for (int i = 0; i < Depth; i++) begin
            tbl_used[i] = 1'b0;
            tbl_next[i] = -1;
        end
        tbl_head     = -1;
        tbl_count    = 0;
        errors       = 0;
        hold_send    = 1'b0;
        done_feeding = 1'b0;

        // Directed: empty-table cases, extremes, duplicates, fill to full.
        cmd_q.push_back(cmd(OpList, 16'h1234, '1));
        cmd_q.push_back(cmd(OpDelete, 16'hFFFF, '0));
        cmd_q.push_back(cmd(OpSearch, 16'h0000, '0));
        cmd_q.push_back(cmd(OpInsert, 16'hFFFF, '1));
        cmd_q.push_back(cmd(OpInsert, 16'h0000, '0));
        cmd_q.push_back(cmd(OpInsert, 16'h8000, 64'hAAAA_5555_AAAA_5555));
        cmd_q.push_back(cmd(OpInsert, 16'h8000, 64'h5555_AAAA_5555_AAAA));
        cmd_q.push_back(cmd(OpSearch, 16'h8000, '0));
        cmd_q.push_back(cmd(OpSearch, 16'h7FFF, '0));
        cmd_q.push_back(cmd(OpList, 16'h0, '0));
        cmd_q.push_back(cmd(OpDelete, 16'h8000, '0));
        cmd_q.push_back(cmd(OpDelete, 16'h0001, '0));
        cmd_q.push_back(cmd(OpDelete, 16'h0000, '0));
        for (int i = 0; i < Depth + 1; i++)
            cmd_q.push_back(cmd(OpInsert, 16'($urandom_range(0, 40)), rand_pay()));
        cmd_q.push_back(cmd(OpList, 16'h0, '0));

        // Random: small key range so hits and duplicates are common.
        for (int i = 0; i < 235; i++) begin
            sel = $urandom_range(0, 99);
            op  = (sel < 40) ? OpInsert : (sel < 70) ? OpDelete :
                  (sel < 90) ? OpSearch : OpList;
            cmd_q.push_back(cmd(op, ($urandom_range(0, 3) == 0) ? 16'($urandom) :
                                16'($urandom_range(0, 47)), rand_pay()));
            if (i == 170) cmd_q.push_back(cmd(OpList, 16'hFFFF, '0));
        end
        // Delete each key from 0 to 47 twice to thin the table late in the run.
        for (int k = 0; k < 48; k++) begin
            cmd_q.push_back(cmd(OpDelete, 16'(k), '0));
            cmd_q.push_back(cmd(OpDelete, 16'(k), '0));
        end
        cmd_q.push_back(cmd(OpList, 16'h0, '0));
        done_feeding = 1'b1;
    end

    // Driver.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            send_gap      <= $urandom_range(0, 18);
        end else if (s_axis_tvalid && !s_axis_tready) begin
            // hold the word
        end else if (s_axis_tvalid) begin
            table_apply(cmd_q.pop_front());
            s_axis_tvalid <= 1'b0;
            send_gap      <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18);
            // One pause for all results once the random part is under way.
            if (cmd_q.size() == 200) hold_send <= 1'b1;
        end else if (hold_send) begin
            if (result_q.size() == 0) hold_send <= 1'b0;
        end else if (send_gap > 0) begin
            send_gap <= send_gap - 1;
        end else if (cmd_q.size() > 0) begin
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= {6'b0, cmd_q[0]};
        end
    end

    // Monitor.
    always @(posedge i_clk) begin
        t_result got, want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            recv_gap      <= 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = {m_axis_tlast, m_axis_tdata[81:0]};
                if (result_q.size() == 0) begin
                    $error("unexpected result word %h", m_axis_tdata);
                    errors++;
                end else begin
                    want = result_q.pop_front();
                    if (got.status !== want.status) begin
                        $error("status exp %0d got %0d", want.status, got.status);
                        errors++;
                    end
                    if (got.key !== want.key) begin
                        $error("rec_key exp %h got %h", want.key, got.key);
                        errors++;
                    end
                    if (got.payload !== want.payload) begin
                        $error("rec_payload exp %h got %h", want.payload, got.payload);
                        errors++;
                    end
                    if (got.last !== want.last) begin
                        $error("last exp %0d got %0d", want.last, got.last);
                        errors++;
                    end
                end
                recv_gap      <= $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 18);
                m_axis_tready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap      <= recv_gap - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Watchdog and end of run.
    initial begin
        i_rst_n = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        idle_cycles = 0;
        while (!(done_feeding && cmd_q.size() == 0 && !s_axis_tvalid
                 && result_q.size() == 0) && idle_cycles < 5000) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        if (idle_cycles >= 5000) begin
            $display("[sorted_linked_table_top] ERROR");
        end else begin
            repeat (200) @(posedge i_clk);
            if (errors == 0 && result_q.size() == 0)
                $display("[sorted_linked_table_top] OK");
            else
                $display("[sorted_linked_table_top] ERROR");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/slt_pkg.sv
rtl/sorted_linked_table_top.sv
tb/tb_sorted_linked_table_top.sv
